[hw/rtl/aip_pkg.sv]
package aip_pkg;

   localparam int CH_W        = 8;
   localparam int VALUE_W     = 64;
   localparam int COUNT_W     = 8;
   localparam int DIGIT_W     = 4;
   localparam int BASE_W      = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam int MAX_CONSUMED_DEF = 255;
   localparam int QUEUE_DEPTH_DEF  = 4;

   // Register index of base_mode.
   localparam logic CSR_IDX_BASE_MODE = 1'b0;

   localparam logic [BASE_W-1:0] BASE_AUTO = 2'd0;
   localparam logic [BASE_W-1:0] BASE_OCT  = 2'd1;
   localparam logic [BASE_W-1:0] BASE_DEC  = 2'd2;
   localparam logic [BASE_W-1:0] BASE_HEX  = 2'd3;

   localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
   localparam logic [CH_W-1:0] CH_PLUS  = 8'h2b;
   localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;
   localparam logic [CH_W-1:0] CH_0     = 8'h30;
   localparam logic [CH_W-1:0] CH_7     = 8'h37;
   localparam logic [CH_W-1:0] CH_9     = 8'h39;
   localparam logic [CH_W-1:0] CH_UA    = 8'h41;
   localparam logic [CH_W-1:0] CH_UF    = 8'h46;
   localparam logic [CH_W-1:0] CH_UX    = 8'h58;
   localparam logic [CH_W-1:0] CH_LA    = 8'h61;
   localparam logic [CH_W-1:0] CH_LF    = 8'h66;
   localparam logic [CH_W-1:0] CH_LX    = 8'h78;

   // One classified character as it travels from the front to the back.
   typedef struct packed {
      logic               first;
      logic               is_blank;
      logic               is_minus;
      logic               is_plus;
      logic               is_zero;
      logic               is_x;
      logic               oct_ok;
      logic               dec_ok;
      logic               hex_ok;
      logic [DIGIT_W-1:0] digit;
   } cls_type;

endpackage

[hw/rtl/aip_req_if.sv]
interface aip_req_if;
   import aip_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;
   logic            first;

   modport source (output valid, output ch, output first, input ready);
   modport sink   (input valid, input ch, input first, output ready);

endinterface

[hw/rtl/aip_rsp_if.sv]
interface aip_rsp_if;
   import aip_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic [COUNT_W-1:0] consumed;

   modport source (output valid, output value, output consumed, input ready);
   modport sink   (input valid, input value, input consumed, output ready);

endinterface

[hw/rtl/ascii_integer_parser_top.sv]
// ASCII integer parser.
// The req channel carries one character per beat (ch, and first to start a new
// number). The rsp channel carries one beat per terminated number: the value,
// negated in two's complement after a minus sign, and the count of characters
// consumed before the terminator. Numbers restarted by first give no beat.
// The APB port holds base_mode at offset 0 (0 automatic, 1 octal, 2 decimal,
// 3 hexadecimal); the user must write it only while no character is in flight;
// the block does not enforce this. A terminator's result is registered in the
// output register after the queue and back end. Throughput is one character per
// cycle while rsp does not stall; the back end's multiply-add is combinational.
// A four-entry queue sits between the classifying front end and the back end.
// When rsp stalls, the output register holds its beat, the back end stops, and
// req stays ready until the queue fills. A character that gives no result still
// passes through the back end in order.
// Reset (synchronous) empties the queue and the output register, clears
// base_mode to automatic, and leaves the parser waiting for a first character.
module ascii_integer_parser_top
   import aip_pkg::*;
#(
   parameter int MAX_CONSUMED = MAX_CONSUMED_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   aip_req_if.sink               req,
   aip_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [BASE_W-1:0] base_mode_ff;
   logic              q_ready;
   logic              q_push;
   cls_type           push_entry;
   logic              q_valid;
   logic              q_pop;
   cls_type           pop_entry;
   logic              csr_sel_base;

   assign csr_pready   = 1'b1;
   assign csr_sel_base = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_BASE_MODE);
   assign csr_prdata   = csr_sel_base ? CSR_DATA_W'(base_mode_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_mode_ff <= BASE_AUTO;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_sel_base) begin
         base_mode_ff <= csr_pwdata[BASE_W-1:0];
      end
   end

   aip_front u_front (
      .req     (req),
      .q_ready (q_ready),
      .q_push  (q_push),
      .q_entry (push_entry)
   );

   aip_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .push_ready (q_ready),
      .pop        (q_pop),
      .pop_valid  (q_valid),
      .pop_entry  (pop_entry)
   );

   aip_back #(
      .MAX_CONSUMED (MAX_CONSUMED)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .base_mode (base_mode_ff),
      .q_valid   (q_valid),
      .q_entry   (pop_entry),
      .q_pop     (q_pop),
      .rsp       (rsp)
   );

endmodule

[hw/rtl/aip_front.sv]
module aip_front
   import aip_pkg::*;
(
   aip_req_if.sink   req,
   input  logic      q_ready,
   output logic      q_push,
   output cls_type   q_entry
);

   logic [CH_W-1:0] ch;
   logic            is_dec;
   logic            is_upper;
   logic            is_lower;
   logic [CH_W-1:0] dval;

   assign ch = req.ch;

   assign req.ready = q_ready;
   assign q_push    = req.valid && q_ready;

   assign is_dec   = (ch >= CH_0) && (ch <= CH_9);
   assign is_upper = (ch >= CH_UA) && (ch <= CH_UF);
   assign is_lower = (ch >= CH_LA) && (ch <= CH_LF);

   always_comb begin
      if (is_upper) begin
         dval = ch - CH_UA + 8'd10;
      end else if (is_lower) begin
         dval = ch - CH_LA + 8'd10;
      end else begin
         dval = ch - CH_0;
      end
   end

   always_comb begin
      q_entry.first    = req.first;
      q_entry.is_blank = (ch == CH_SPACE) || (ch == CH_TAB);
      q_entry.is_minus = (ch == CH_MINUS);
      q_entry.is_plus  = (ch == CH_PLUS);
      q_entry.is_zero  = (ch == CH_0);
      q_entry.is_x     = (ch == CH_LX) || (ch == CH_UX);
      q_entry.oct_ok   = (ch >= CH_0) && (ch <= CH_7);
      q_entry.dec_ok   = is_dec;
      q_entry.hex_ok   = is_dec || is_upper || is_lower;
      q_entry.digit    = dval[DIGIT_W-1:0];
   end

endmodule

[hw/rtl/aip_queue.sv]
module aip_queue
   import aip_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cls_type push_entry,
   output logic    push_ready,
   input  logic    pop,
   output logic    pop_valid,
   output cls_type pop_entry
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL = CW'(DEPTH);

   cls_type         mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign push_ready = (count_ff != FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (push_ready || pop))
      else $error("queue written while full");
`endif

endmodule

[hw/rtl/aip_back.sv]
module aip_back
   import aip_pkg::*;
#(
   parameter int MAX_CONSUMED = MAX_CONSUMED_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [BASE_W-1:0] base_mode,
   input  logic              q_valid,
   input  cls_type           q_entry,
   output logic              q_pop,
   aip_rsp_if.source         rsp
);

   localparam int CAP_I = (MAX_CONSUMED < 255) ? MAX_CONSUMED : 255;
   localparam logic [COUNT_W-1:0] CNT_CAP = COUNT_W'(CAP_I);

   typedef enum logic [2:0] {
      PH_DONE,
      PH_LEAD,
      PH_POSTSIGN,
      PH_ZERO,
      PH_DIGITS
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic               neg_ff, neg_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [BASE_W-1:0]  base_ff, base_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_value_ff;
   logic [COUNT_W-1:0] rsp_consumed_ff;
   logic               emit;
   logic [VALUE_W-1:0] emit_value;

   // The output register frees up in the same cycle that its beat is taken.
   assign q_pop = q_valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      phase_type          ph;
      logic               neg;
      logic [VALUE_W-1:0] acc;
      logic [BASE_W-1:0]  db;
      logic [COUNT_W-1:0] cnt;
      logic               bump;
      logic               do_digit;
      logic               ok;
      logic [VALUE_W-1:0] scaled;

      ph       = q_entry.first ? PH_LEAD : phase_ff;
      neg      = q_entry.first ? 1'b0 : neg_ff;
      acc      = q_entry.first ? '0 : acc_ff;
      db       = q_entry.first ? BASE_AUTO : base_ff;
      cnt      = q_entry.first ? '0 : cnt_ff;
      bump     = 1'b0;
      do_digit = 1'b0;
      ok       = 1'b0;
      scaled   = '0;
      emit     = 1'b0;
      phase_in = ph;

      unique case (ph)
         PH_LEAD, PH_POSTSIGN: begin
            if (q_entry.is_blank) begin
               bump = 1'b1;
            end else if (ph == PH_LEAD && q_entry.is_minus) begin
               neg      = 1'b1;
               bump     = 1'b1;
               phase_in = PH_POSTSIGN;
            end else if (ph == PH_LEAD && q_entry.is_plus) begin
               bump     = 1'b1;
               phase_in = PH_POSTSIGN;
            end else if (base_mode != BASE_AUTO) begin
               db       = base_mode;
               do_digit = 1'b1;
            end else if (q_entry.is_zero) begin
               bump     = 1'b1;
               phase_in = PH_ZERO;
            end else begin
               db       = BASE_DEC;
               do_digit = 1'b1;
            end
         end
         PH_ZERO: begin
            if (q_entry.is_x) begin
               db       = BASE_HEX;
               bump     = 1'b1;
               phase_in = PH_DIGITS;
            end else begin
               db       = BASE_OCT;
               do_digit = 1'b1;
            end
         end
         PH_DIGITS: begin
            do_digit = 1'b1;
         end
         PH_DONE: begin
         end
         default: begin
            phase_in = PH_DONE;
         end
      endcase

      emit_value = neg ? (~acc + 1'b1) : acc;

      case (db)
         BASE_OCT: ok = q_entry.oct_ok;
         BASE_HEX: ok = q_entry.hex_ok;
         default:  ok = q_entry.dec_ok;
      endcase

      case (db)
         BASE_OCT: scaled = acc << 3;
         BASE_HEX: scaled = acc << 4;
         default:  scaled = (acc << 3) + (acc << 1);
      endcase

      if (do_digit) begin
         if (ok) begin
            acc      = scaled + VALUE_W'(q_entry.digit);
            bump     = 1'b1;
            phase_in = PH_DIGITS;
         end else begin
            emit     = 1'b1;
            phase_in = PH_DONE;
         end
      end

      if (bump && (cnt < CNT_CAP)) begin
         cnt = cnt + 1'b1;
      end

      neg_in  = neg;
      acc_in  = acc;
      base_in = db;
      cnt_in  = cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_DONE;
         neg_ff       <= 1'b0;
         acc_ff       <= '0;
         base_ff      <= BASE_AUTO;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            phase_ff <= phase_in;
            neg_ff   <= neg_in;
            acc_ff   <= acc_in;
            base_ff  <= base_in;
            cnt_ff   <= cnt_in;
         end
         if (q_pop && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && emit) begin
         rsp_value_ff    <= emit_value;
         rsp_consumed_ff <= cnt_ff & {COUNT_W{!q_entry.first}};
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.value    = rsp_value_ff;
   assign rsp.consumed = rsp_consumed_ff;

`ifndef SYNTHESIS
   a_emit_ends_number: assert property (@(posedge clock) disable iff (reset)
      (q_pop && emit) |=> (rsp_valid_ff && phase_ff == PH_DONE))
      else $error("terminator did not produce a result and end the number");

   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_CAP)
      else $error("character count above its cap");

   a_idle_char_ignored: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !q_entry.first && phase_ff == PH_DONE)
      |=> (phase_ff == PH_DONE && $stable(acc_ff) && $stable(cnt_ff)))
      else $error("character outside a number changed state");
`endif

endmodule
